// File: src/cfba_pkg.sv
// Shared types and constants of the chained free-block allocator.
package cfba_pkg;

  localparam int unsigned BLK_W            = 10;
  localparam int unsigned STATUS_W         = 2;
  localparam int unsigned TDATA_IN_W       = 16;
  localparam int unsigned TDATA_OUT_W      = 16;
  localparam int unsigned GROUP_SIZE_DEF   = 152;
  localparam int unsigned NUM_BLOCKS_DEF   = 1024;

  typedef enum logic [0:0] {
    REQ_FREE  = 1'b0,
    REQ_ALLOC = 1'b1
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC  = 2'd0,
    ST_FREED  = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_REJECT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SPILL,
    S_REFILL
  } ctrl_state_e;

  typedef struct packed {
    status_e          status;
    logic [BLK_W-1:0] granted;
  } resp_t;

endpackage

// File: src/cfba_cache_mem.sv
// Cache stack memory with per-entry valid bits; an entry never written reads as zero.
module cfba_cache_mem
  import cfba_pkg::*;
#(
  parameter int unsigned DEPTH = GROUP_SIZE_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [BLK_W-1:0] wdata_i,
  output logic [BLK_W-1:0] rdata_o
);

  logic [BLK_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_q;
  logic [BLK_W-1:0] rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (we_i) begin
      valid_q[waddr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= valid_q[raddr_i] ? mem[raddr_i] : '0;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cfba_spill_mem.sv
// Backing store of spilled groups, one row of GROUP_SIZE entries per block.
module cfba_spill_mem
  import cfba_pkg::*;
#(
  parameter int unsigned DEPTH = GROUP_SIZE_DEF * NUM_BLOCKS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [BLK_W-1:0] wdata_i,
  output logic [BLK_W-1:0] rdata_o
);

  logic [BLK_W-1:0] mem [DEPTH];
  logic [BLK_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/cfba_ctrl.sv
// Request sequencer: stack count, pop read, spill and refill sweeps.
module cfba_ctrl
  import cfba_pkg::*;
#(
  parameter int unsigned GROUP_SIZE = GROUP_SIZE_DEF,
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF,
  parameter int unsigned AW         = $clog2(GROUP_SIZE),
  parameter int unsigned SAW        = $clog2(GROUP_SIZE * NUM_BLOCKS)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  req_e             req_type_i,
  input  logic [BLK_W-1:0] block_number_i,
  input  logic             out_free_i,
  output logic             resp_valid_o,
  output resp_t            resp_o,
  output logic             cache_re_o,
  output logic [AW-1:0]    cache_raddr_o,
  output logic             cache_we_o,
  output logic [AW-1:0]    cache_waddr_o,
  output logic [BLK_W-1:0] cache_wdata_o,
  input  logic [BLK_W-1:0] cache_rdata_i,
  output logic             spill_re_o,
  output logic [SAW-1:0]   spill_raddr_o,
  output logic             spill_we_o,
  output logic [SAW-1:0]   spill_waddr_o,
  output logic [BLK_W-1:0] spill_wdata_o,
  input  logic [BLK_W-1:0] spill_rdata_i
);

  localparam int unsigned CW = $clog2(GROUP_SIZE + 1);

  ctrl_state_e      state_q, state_d;
  logic [CW-1:0]    count_q, count_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    cnt_m1;
  logic [SAW-1:0]   base_q, base_d;
  logic [BLK_W-1:0] blk_q, blk_d;
  logic             zero_fill_q, zero_fill_d;
  logic             accept;
  logic             reject;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= CW'(1);
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    blk_q       <= blk_d;
    zero_fill_q <= zero_fill_d;
  end

  assign req_ready_o = (state_q == S_IDLE) && out_free_i;
  assign accept      = req_valid_i && req_ready_o;
  assign reject      = (block_number_i == '0) || (32'(block_number_i) >= 32'(NUM_BLOCKS));
  assign cnt_m1      = cnt_q - CW'(1);

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    cnt_d         = cnt_q;
    base_d        = base_q;
    blk_d         = blk_q;
    zero_fill_d   = zero_fill_q;
    resp_valid_o  = 1'b0;
    resp_o        = '{status: ST_FREED, granted: '0};
    cache_re_o    = 1'b0;
    cache_raddr_o = '0;
    cache_we_o    = 1'b0;
    cache_waddr_o = '0;
    cache_wdata_o = block_number_i;
    spill_re_o    = 1'b0;
    spill_raddr_o = base_q + SAW'(cnt_q);
    spill_we_o    = 1'b0;
    spill_waddr_o = base_q + SAW'(cnt_m1);
    spill_wdata_o = cache_rdata_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_FREE) begin
            resp_valid_o = 1'b1;
            if (reject) begin
              resp_o.status = ST_REJECT;
            end else if (count_q >= CW'(GROUP_SIZE)) begin
              // Full cache: copy it into the freed block's row first.
              base_d  = SAW'(32'(block_number_i) * 32'(GROUP_SIZE));
              blk_d   = block_number_i;
              cnt_d   = '0;
              state_d = S_SPILL;
            end else begin
              cache_we_o    = 1'b1;
              cache_waddr_o = count_q[AW-1:0];
              count_d       = count_q + CW'(1);
            end
          end else if (count_q == '0) begin
            resp_valid_o  = 1'b1;
            resp_o.status = ST_EMPTY;
          end else begin
            cache_re_o    = 1'b1;
            cache_raddr_o = AW'(count_q - CW'(1));
            state_d       = S_POP;
          end
        end
      end

      S_POP: begin
        resp_valid_o = 1'b1;
        state_d      = S_IDLE;
        if (cache_rdata_i == '0) begin
          resp_o.status = ST_EMPTY;
        end else begin
          resp_o.status  = ST_ALLOC;
          resp_o.granted = cache_rdata_i;
          if (count_q == CW'(1)) begin
            // Chain block popped: reload its group as a full cache.
            count_d     = CW'(GROUP_SIZE);
            base_d      = SAW'(32'(cache_rdata_i) * 32'(GROUP_SIZE));
            zero_fill_d = 32'(cache_rdata_i) >= 32'(NUM_BLOCKS);
            cnt_d       = '0;
            state_d     = S_REFILL;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
      end

      S_SPILL: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q < CW'(GROUP_SIZE)) begin
          cache_re_o    = 1'b1;
          cache_raddr_o = cnt_q[AW-1:0];
        end
        if (cnt_q != '0) begin
          spill_we_o = 1'b1;
        end
        if (cnt_q == CW'(GROUP_SIZE)) begin
          cache_we_o    = 1'b1;
          cache_waddr_o = '0;
          cache_wdata_o = blk_q;
          count_d       = CW'(1);
          cnt_d         = '0;
          state_d       = S_IDLE;
        end
      end

      S_REFILL: begin
        cnt_d = cnt_q + CW'(1);
        if (cnt_q < CW'(GROUP_SIZE)) begin
          spill_re_o = 1'b1;
        end
        if (cnt_q != '0) begin
          cache_we_o    = 1'b1;
          cache_waddr_o = cnt_m1[AW-1:0];
          cache_wdata_o = zero_fill_q ? '0 : spill_rdata_i;
        end
        if (cnt_q == CW'(GROUP_SIZE)) begin
          cnt_d   = '0;
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// File: src/chained_free_block_allocator_top.sv
// Top level of the chained free-block allocator with its stream ports and result register.
//
// Each input transaction is a free or an allocate request; each yields exactly one result
// transaction (granted block, status). A free that fits in the cache is answered from
// the idle state; an allocate first passes a pop state for the synchronous cache read of
// the stack top. A free into a full cache spills the whole cache into the freed block's
// row of the backing store, one entry a cycle. An allocate that pops the last entry (the
// chain block) refills the cache from that block's row, again one entry a cycle. Both
// sweeps are bounded by the one read port and one write port of each memory. The result
// of a request is presented as soon as it is known, also at the start of a sweep; the
// next request is taken once the sweep is done. The cache resets to all zero through
// per-entry valid bits, so no clearing pass follows reset; the backing store is not
// cleared and only rows that were spilled are ever read back.
module chained_free_block_allocator_top
  import cfba_pkg::*;
#(
  parameter int unsigned GROUP_SIZE = GROUP_SIZE_DEF,
  parameter int unsigned NUM_BLOCKS = NUM_BLOCKS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [TDATA_IN_W-1:0]  s_axis_tdata_i,   // [9:0] block_number, rest zero
  input  logic [0:0]             s_axis_tuser_i,   // [0] req_type
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  output logic [TDATA_OUT_W-1:0] m_axis_tdata_o    // [9:0] granted_block, [11:10] status
);

  localparam int unsigned AW  = $clog2(GROUP_SIZE);
  localparam int unsigned SAW = $clog2(GROUP_SIZE * NUM_BLOCKS);

  logic             out_valid_q;
  resp_t            out_data_q;
  logic             out_free;
  logic             resp_valid;
  resp_t            resp;

  logic             cache_re, cache_we;
  logic [AW-1:0]    cache_raddr, cache_waddr;
  logic [BLK_W-1:0] cache_wdata, cache_rdata;
  logic             spill_re, spill_we;
  logic [SAW-1:0]   spill_raddr, spill_waddr;
  logic [BLK_W-1:0] spill_wdata, spill_rdata;

  // Output register is free when empty or when its transaction completes this cycle.
  assign out_free = !out_valid_q || m_axis_tready_i;

  cfba_ctrl #(
    .GROUP_SIZE (GROUP_SIZE),
    .NUM_BLOCKS (NUM_BLOCKS),
    .AW         (AW),
    .SAW        (SAW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid_i),
    .req_ready_o    (s_axis_tready_o),
    .req_type_i     (req_e'(s_axis_tuser_i[0])),
    .block_number_i (s_axis_tdata_i[BLK_W-1:0]),
    .out_free_i     (out_free),
    .resp_valid_o   (resp_valid),
    .resp_o         (resp),
    .cache_re_o     (cache_re),
    .cache_raddr_o  (cache_raddr),
    .cache_we_o     (cache_we),
    .cache_waddr_o  (cache_waddr),
    .cache_wdata_o  (cache_wdata),
    .cache_rdata_i  (cache_rdata),
    .spill_re_o     (spill_re),
    .spill_raddr_o  (spill_raddr),
    .spill_we_o     (spill_we),
    .spill_waddr_o  (spill_waddr),
    .spill_wdata_o  (spill_wdata),
    .spill_rdata_i  (spill_rdata)
  );

  cfba_cache_mem #(
    .DEPTH (GROUP_SIZE),
    .AW    (AW)
  ) u_cache (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .re_i    (cache_re),
    .raddr_i (cache_raddr),
    .we_i    (cache_we),
    .waddr_i (cache_waddr),
    .wdata_i (cache_wdata),
    .rdata_o (cache_rdata)
  );

  cfba_spill_mem #(
    .DEPTH (GROUP_SIZE * NUM_BLOCKS),
    .AW    (SAW)
  ) u_spill (
    .clk_i   (clk_i),
    .re_i    (spill_re),
    .raddr_i (spill_raddr),
    .we_i    (spill_we),
    .waddr_i (spill_waddr),
    .wdata_i (spill_wdata),
    .rdata_o (spill_rdata)
  );

  // Result register: load on a new result, drop once the transaction completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (resp_valid) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_valid) begin
      out_data_q <= resp;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = TDATA_OUT_W'({out_data_q.status, out_data_q.granted});

endmodule

// File: src/cfba_checker.sv
// Port-level checks of the allocator, bound to the top level.
module cfba_checker
  import cfba_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid_i,
  input logic                   s_axis_tready_o,
  input logic [TDATA_IN_W-1:0]  s_axis_tdata_i,
  input logic [0:0]             s_axis_tuser_i,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [TDATA_OUT_W-1:0] m_axis_tdata_o
);

  logic [BLK_W-1:0]    granted;
  logic [STATUS_W-1:0] status;

  assign granted = m_axis_tdata_o[BLK_W-1:0];
  assign status  = m_axis_tdata_o[BLK_W+STATUS_W-1:BLK_W];

  // Only an allocation carries a block number, and it is never the end marker.
  a_grant_only_on_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status != ST_ALLOC) |-> granted == '0)
    else $error("nonzero block on a non-allocate result");

  a_alloc_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (status == ST_ALLOC) |-> granted != '0)
    else $error("allocate result with block zero");

  // A waiting result blocks new requests.
  a_no_accept_when_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |-> !s_axis_tready_o)
    else $error("request taken while result register is held");

  // Freeing block zero is rejected in the very next cycle.
  a_free_zero_rejected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && (s_axis_tuser_i[0] == REQ_FREE)
      && (s_axis_tdata_i[BLK_W-1:0] == '0)
    |=> m_axis_tvalid_o && (status == ST_REJECT))
    else $error("free of block zero not rejected");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("stalled result changed");

endmodule

bind chained_free_block_allocator_top cfba_checker u_cfba_checker (.*);

// File: tb/testbench.sv
// Self-checking testbench of the chained free-block allocator: directed edges, then spill/refill traffic.
module testbench;
  import cfba_pkg::*;

  localparam int unsigned GS          = GROUP_SIZE_DEF;
  localparam int unsigned NB          = NUM_BLOCKS_DEF;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned PRINT_CAP   = 30;

  // Clock, reset and the stream signals on both sides of the block.
  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   s_valid;
  logic                   s_ready;
  logic [TDATA_IN_W-1:0]  s_data;    // [9:0] block_number, rest zero
  logic [0:0]             s_user;    // [0] req_type
  logic                   m_valid;
  logic                   m_ready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_data;    // [9:0] granted_block, [11:10] status

  // Idle odds in percent, changed per traffic phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // Shadow of the allocator: cache stack, its count and the spilled group rows.
  logic [BLK_W-1:0] stack_entries [GS];
  int unsigned      stack_count;
  logic [BLK_W-1:0] group_rows [NB][GS];

  // Responses still owed by the block, oldest first.
  resp_t awaited_responses [$];

  int unsigned error_count   = 0;
  int unsigned cycle_count   = 0;
  int unsigned grants_seen   = 0;
  int unsigned frees_seen    = 0;
  int unsigned empties_seen  = 0;
  int unsigned rejects_seen  = 0;
  int unsigned spill_count   = 0;
  int unsigned refill_count  = 0;

  chained_free_block_allocator_top dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),
    .s_axis_tuser_i  (s_user),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data)
  );

  always #5 clk = ~clk;

  // Bound the run; a hang anywhere ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycle_count, awaited_responses.size());
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < PRINT_CAP) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Apply one request to the shadow state and return the response it must produce.
  function automatic resp_t apply_request(req_e req, logic [BLK_W-1:0] blk);
    resp_t            r;
    logic [BLK_W-1:0] top_blk;
    r.granted = '0;
    if (req == REQ_FREE) begin
      if (blk == '0 || blk >= NB) begin
        r.status = ST_REJECT;
        rejects_seen++;
      end else if (stack_count >= GS) begin
        // Full cache: copy it whole into the freed block's row, restart with that block.
        for (int i = 0; i < GS; i++) group_rows[blk][i] = stack_entries[i];
        stack_entries[0] = blk;
        stack_count      = 1;
        r.status         = ST_FREED;
        spill_count++;
        frees_seen++;
      end else begin
        stack_entries[stack_count] = blk;
        stack_count++;
        r.status = ST_FREED;
        frees_seen++;
      end
    end else begin
      top_blk = (stack_count == 0) ? '0 : stack_entries[stack_count-1];
      if (top_blk == '0) begin
        // End-of-chain marker on top: nothing to grant, count stays put.
        r.status = ST_EMPTY;
        empties_seen++;
      end else begin
        stack_count--;
        if (stack_count == 0) begin
          // Popped the chain block: reload its row as a full cache.
          for (int i = 0; i < GS; i++) stack_entries[i] = group_rows[top_blk][i];
          stack_count = GS;
          refill_count++;
        end
        r.granted = top_blk;
        r.status  = ST_ALLOC;
        grants_seen++;
      end
    end
    return r;
  endfunction

  // Predict on every accepted request transaction.
  always @(posedge clk) begin
    if (rst_n && s_valid && s_ready)
      awaited_responses.push_back(apply_request(req_e'(s_user), s_data[BLK_W-1:0]));
  end

  // Check every accepted response transaction against the oldest expectation.
  always @(posedge clk) begin
    resp_t want;
    logic [BLK_W-1:0] got_blk;
    status_e          got_status;
    if (rst_n && m_valid && m_ready) begin
      got_blk    = m_data[BLK_W-1:0];
      got_status = status_e'(m_data[BLK_W +: STATUS_W]);
      if (awaited_responses.size() == 0) begin
        report_mismatch($sformatf("unexpected response blk=%0d status=%0d",
                                  got_blk, got_status));
      end else begin
        want = awaited_responses.pop_front();
        if (got_blk !== want.granted)
          report_mismatch($sformatf("granted_block %0d, want %0d", got_blk, want.granted));
        if (got_status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", got_status, want.status));
      end
    end
  end

  // Receiver side: stall at random, one decision per cycle.
  always @(negedge clk) begin
    m_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Present one request and hold it until the block takes it; return at a falling edge.
  task automatic send_request(input req_e req, input logic [BLK_W-1:0] blk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_valid <= 1'b0;
      @(negedge clk);
    end
    s_valid <= 1'b1;
    s_data  <= TDATA_IN_W'(blk);
    s_user  <= req;
    do @(posedge clk); while (!s_ready);
    @(negedge clk);
  endtask

  // Hold off the sender until the block owes nothing.
  task automatic hold_until_drained();
    s_valid <= 1'b0;
    @(negedge clk);
    while (awaited_responses.size() != 0) @(negedge clk);
  endtask

  function automatic logic [BLK_W-1:0] pick_block();
    case ($urandom_range(19))
      0:       return BLK_W'(1);
      1:       return BLK_W'(NB - 1);
      2:       return BLK_W'(512);
      3:       return BLK_W'(511);
      default: return BLK_W'($urandom_range(1, NB - 1));
    endcase
  endfunction

  // Empty-at-reset, block zero, bit extremes, LIFO order and double free.
  task automatic test_directed();
    send_idle_pct = 18;
    recv_idle_pct = 67;
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '1);
    send_request(REQ_FREE,  '0);
    send_request(REQ_FREE,  BLK_W'(1023));
    send_request(REQ_FREE,  BLK_W'(1));
    send_request(REQ_FREE,  BLK_W'(682));
    send_request(REQ_FREE,  BLK_W'(341));
    send_request(REQ_FREE,  '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, BLK_W'(682));
    send_request(REQ_FREE,  BLK_W'(5));
    send_request(REQ_FREE,  BLK_W'(5));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, BLK_W'(341));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '1);
    send_request(REQ_FREE,  BLK_W'(512));
    send_request(REQ_FREE,  BLK_W'(511));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '0);
  endtask

  // Bursts of fill, drain, mixed and noise traffic; the first two bursts force a
  // spill and a chain refill so every phase walks the group copy paths.
  task automatic test_traffic(input int unsigned n_items, input int unsigned s_idle,
                              input int unsigned r_idle);
    int unsigned sent;
    int unsigned burst;
    int unsigned burst_len;
    int unsigned mode;
    int unsigned roll;
    req_e             req;
    logic [BLK_W-1:0] blk;
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    sent  = 0;
    burst = 0;
    hold_until_drained();
    while (sent < n_items) begin
      if (burst == 0)      mode = 0;
      else if (burst == 1) mode = 60;
      else                 mode = $urandom_range(99);
      burst_len = (burst < 2) ? 220 : $urandom_range(100, 300);
      for (int k = 0; k < burst_len && sent < n_items; k++) begin
        roll = $urandom_range(99);
        blk  = pick_block();
        if (mode < 45)      req = (roll < 90) ? REQ_FREE : REQ_ALLOC;
        else if (mode < 80) req = (roll < 90) ? REQ_ALLOC : REQ_FREE;
        else if (mode < 92) req = (roll < 50) ? REQ_FREE : REQ_ALLOC;
        else begin
          req = (roll < 70) ? REQ_FREE : REQ_ALLOC;
          if (roll < 40) blk = '0;
        end
        // Allocate ignores the block field; keep it noisy.
        if (req == REQ_ALLOC) blk = BLK_W'($urandom_range(0, NB - 1));
        send_request(req, blk);
        sent++;
      end
      burst++;
      if ($urandom_range(3) == 0) hold_until_drained();
    end
  endtask

  initial begin
    rst_n   = 1'b0;
    s_valid = 1'b0;
    s_data  = '0;
    s_user  = '0;
    stack_count = 1;
    for (int i = 0; i < GS; i++) stack_entries[i] = '0;
    for (int b = 0; b < NB; b++)
      for (int i = 0; i < GS; i++) group_rows[b][i] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_directed();
    test_traffic(545, 18, 67);
    test_traffic(545, 67, 18);
    test_traffic(545, 0, 0);

    // Drain, then linger past a full group sweep so a stray response would show.
    s_valid <= 1'b0;
    @(negedge clk);
    while (awaited_responses.size() != 0) @(negedge clk);
    repeat (GS + 16) @(negedge clk);

    $display("covered %0d grants, %0d frees, %0d empty allocates, %0d rejected frees",
             grants_seen, frees_seen, empties_seen, rejects_seen);
    $display("group spills %0d, chain refills %0d, mismatches %0d",
             spill_count, refill_count, error_count);
    if (error_count == 0 && awaited_responses.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
